// ===== rtl/cswf_pkg.sv =====
// Shared types, constants and helpers for the cosmic spike window filter.
`timescale 1ns / 1ps

package cswf_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int WIN_LEN     = 7;
   localparam int FILL_W      = 3;
   localparam int MAX_RESULTS = 7;
   localparam int RES_CNT_W   = 3;

   localparam int OFFSET_W = 23;
   localparam int RATIO_W  = 8;
   localparam int CSR_W    = 23;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SPIKE_OFFSET = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIKE_RATIO  = 1'b1;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 23'd5000;
   localparam logic [RATIO_W-1:0]  RATIO_RESET  = 8'd80;

   // threshold widths: median + offset, and ratio * median
   localparam int ADD_W = SAMPLE_W + 2;
   localparam int MUL_W = SAMPLE_W + RATIO_W + 1;

   localparam int FIFO_DEPTH = 16;
   localparam int PTR_W      = 4;
   localparam int CNT_W      = 5;
   localparam int RSV_W      = 6;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic       last;
      sample_type value;
   } rsp_item_type;

   // what one accepted sample asks the back end to emit
   typedef struct packed {
      logic                 short_v;  // short vector: dump held samples raw
      logic [FILL_W-1:0]    short_n;  // number of held samples in that case
      logic                 head;     // first window: three head samples
      logic                 centre;   // one filtered centre sample
      logic                 tail;     // end of vector: three tail samples
   } op_type;

   function automatic logic [RES_CNT_W-1:0] op_count(input op_type op);
      logic [RES_CNT_W-1:0] n;
      n = '0;
      if (op.short_v) begin
         n = op.short_n;
      end else if (op.head) begin
         n = op.tail ? RES_CNT_W'(7) : RES_CNT_W'(4);
      end else if (op.centre) begin
         n = op.tail ? RES_CNT_W'(4) : RES_CNT_W'(1);
      end
      return n;
   endfunction

endpackage

// ===== rtl/cswf_rsp_fifo.sv =====
// Result queue: takes up to seven items per cycle, hands out one per transfer.
`timescale 1ns / 1ps

module cswf_rsp_fifo
   import cswf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [RES_CNT_W-1:0] push_cnt,
   input  rsp_item_type         push_items [MAX_RESULTS],
   input  logic                 pop,
   output rsp_item_type         head_item,
   output logic [CNT_W-1:0]     count
);

   rsp_item_type     mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_cnt) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // each entry takes the pushed item whose slot lands on it
   always_ff @(posedge clock) begin
      for (int j = 0; j < FIFO_DEPTH; j++) begin
         logic [PTR_W-1:0] ofs;
         ofs = PTR_W'(j) - wr_ptr_ff;
         if (ofs < PTR_W'(push_cnt)) begin
            mem_ff[j] <= push_items[ofs[RES_CNT_W-1:0]];
         end
      end
   end

   assign head_item = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ===== rtl/cosmic_spike_window_filter.sv =====
// Top level of the cosmic spike window filter.
`timescale 1ns / 1ps
//
// Removes single-sample spikes from a stream of signed vectors.
// req_*: one sample per transfer, req_tlast on the final sample of a vector.
// rsp_*: the filtered vector in original order, rsp_tlast on its final sample.
// csr_*: write-only registers, index 0 spike_offset, index 1 spike_ratio
//   (unsigned, 4 fraction bits); write only while no vector is in flight.
// A sample is a spike when it exceeds m + offset or ratio * m: m is the left
// median for head samples, the right one for tail samples, and their max for
// the centre. Output runs three samples behind input: a vector emits its
// first four results on its 7th sample, then one per sample, and the last
// three with its final sample. Vectors shorter than 7 samples come out
// unchanged when their last sample arrives. Results of an accepted sample
// pass the window, median and threshold stages and the result queue before
// they are offered. Throughput: one sample per cycle sustained while the
// receiver keeps up. req_tready is taken from the 16-entry result queue: it
// stays high while the queue plus in-flight results leave room for seven more.
// When the receiver stalls the queue fills and req_tready drops; nothing is
// lost. Reset empties the queue and pipeline, clears the fill count and
// restores the register defaults (offset 5000, ratio 5.0).
//
module cosmic_spike_window_filter
   import cswf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,   // [23:0] sample
   input  logic                 req_tlast,   // last_in
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // [23:0] filtered
   output logic                 rsp_tlast,   // last_out
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // ---------------- helpers
   function automatic sample_type med3(input sample_type a, input sample_type b,
                                      input sample_type c);
      sample_type lo, hi, m;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      m  = (hi < c) ? hi : c;
      return (lo > m) ? lo : m;
   endfunction

   function automatic logic is_spike(input sample_type v,
                                     input logic signed [ADD_W-1:0] thr_add,
                                     input logic signed [MUL_W-1:0] thr_mul);
      logic signed [MUL_W-1:0] v16;
      v16 = MUL_W'(v) <<< 4;
      return (ADD_W'(v) > thr_add) || (v16 > thr_mul);
   endfunction

   // ---------------- configuration
   logic [OFFSET_W-1:0] offset_ff;
   logic [RATIO_W-1:0]  ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
         ratio_ff  <= RATIO_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SPIKE_OFFSET: offset_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_SPIKE_RATIO:  ratio_ff  <= csr_wdata[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- admission
   logic             accept;
   logic [CNT_W-1:0] fifo_count;
   op_type           s1_op_ff, s2_op_ff, s3_op_ff;
   logic [RSV_W-1:0] reserved;

   // worst case for the next sample is a full burst of seven
   assign reserved = RSV_W'(fifo_count) + RSV_W'(op_count(s1_op_ff))
                   + RSV_W'(op_count(s2_op_ff)) + RSV_W'(op_count(s3_op_ff))
                   + RSV_W'(MAX_RESULTS);
   assign req_tready = (reserved <= RSV_W'(FIFO_DEPTH));
   assign accept     = req_tvalid && req_tready;

   // ---------------- stage 1: window and fill count
   sample_type        window_ff [WIN_LEN];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] fill_nxt;
   op_type            op_in;
   sample_type        sample;

   assign sample   = req_tdata[SAMPLE_W-1:0];
   assign fill_nxt = fill_ff + FILL_W'(1);

   always_comb begin
      op_in   = '0;
      fill_in = fill_ff;
      if (accept) begin
         if (fill_ff == FILL_W'(WIN_LEN)) begin
            op_in.centre = 1'b1;
            op_in.tail   = req_tlast;
            fill_in      = req_tlast ? '0 : fill_ff;
         end else if (fill_nxt == FILL_W'(WIN_LEN)) begin
            op_in.head   = 1'b1;
            op_in.centre = 1'b1;
            op_in.tail   = req_tlast;
            fill_in      = req_tlast ? '0 : fill_nxt;
         end else begin
            op_in.short_v = req_tlast;
            op_in.short_n = fill_nxt;
            fill_in       = req_tlast ? '0 : fill_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         s1_op_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         s1_op_ff <= op_in;
      end
   end

   // window contents are always written before they are read
   always_ff @(posedge clock) begin
      if (accept) begin
         if (fill_ff == FILL_W'(WIN_LEN)) begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
               window_ff[i] <= window_ff[i+1];
            end
            window_ff[WIN_LEN-1] <= sample;
         end else begin
            window_ff[fill_ff] <= sample;
         end
      end
   end

   // ---------------- stage 2: neighbor medians
   sample_type s2_win_ff [WIN_LEN];
   sample_type s2_l_ff, s2_r_ff, s2_m_ff;
   sample_type l_in, r_in;

   assign l_in = med3(window_ff[0], window_ff[1], window_ff[2]);
   assign r_in = med3(window_ff[4], window_ff[5], window_ff[6]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_op_ff <= '0;
      end else begin
         s2_op_ff <= s1_op_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_win_ff <= window_ff;
      s2_l_ff   <= l_in;
      s2_r_ff   <= r_in;
      s2_m_ff   <= (l_in > r_in) ? l_in : r_in;
   end

   // ---------------- stage 3: thresholds and replacement value
   sample_type              s3_win_ff [WIN_LEN];
   sample_type              s3_l_ff, s3_r_ff, s3_avg_ff;
   logic signed [ADD_W-1:0] s3_add_l_ff, s3_add_r_ff, s3_add_m_ff;
   logic signed [MUL_W-1:0] s3_mul_l_ff, s3_mul_r_ff, s3_mul_m_ff;
   logic signed [ADD_W-1:0] offset_s;
   logic signed [RATIO_W:0] ratio_s;
   logic signed [SAMPLE_W:0] pair_sum;

   assign offset_s = $signed(ADD_W'(offset_ff));
   assign ratio_s  = $signed({1'b0, ratio_ff});
   assign pair_sum = (SAMPLE_W+1)'(s2_l_ff) + (SAMPLE_W+1)'(s2_r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_op_ff <= '0;
      end else begin
         s3_op_ff <= s2_op_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_win_ff   <= s2_win_ff;
      s3_l_ff     <= s2_l_ff;
      s3_r_ff     <= s2_r_ff;
      s3_avg_ff   <= pair_sum[SAMPLE_W:1];  // floor of the half sum
      s3_add_l_ff <= ADD_W'(s2_l_ff) + offset_s;
      s3_add_r_ff <= ADD_W'(s2_r_ff) + offset_s;
      s3_add_m_ff <= ADD_W'(s2_m_ff) + offset_s;
      s3_mul_l_ff <= MUL_W'(ratio_s) * MUL_W'(s2_l_ff);
      s3_mul_r_ff <= MUL_W'(ratio_s) * MUL_W'(s2_r_ff);
      s3_mul_m_ff <= MUL_W'(ratio_s) * MUL_W'(s2_m_ff);
   end

   // ---------------- stage 4: spike tests, result slots
   rsp_item_type         push_items [MAX_RESULTS];
   logic [RES_CNT_W-1:0] push_cnt;
   rsp_item_type         head_v [3];
   rsp_item_type         tail_v [3];
   rsp_item_type         centre_v;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         head_v[i].last  = 1'b0;
         head_v[i].value = is_spike(s3_win_ff[i], s3_add_l_ff, s3_mul_l_ff)
                         ? s3_l_ff : s3_win_ff[i];
         tail_v[i].last  = (i == 2);
         tail_v[i].value = is_spike(s3_win_ff[i+4], s3_add_r_ff, s3_mul_r_ff)
                         ? s3_r_ff : s3_win_ff[i+4];
      end
      centre_v.last  = 1'b0;
      centre_v.value = is_spike(s3_win_ff[3], s3_add_m_ff, s3_mul_m_ff)
                     ? s3_avg_ff : s3_win_ff[3];
   end

   always_comb begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         push_items[i] = '0;
      end
      if (s3_op_ff.short_v) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            push_items[i].value = s3_win_ff[i];
            push_items[i].last  = (FILL_W'(i + 1) == s3_op_ff.short_n);
         end
      end else if (s3_op_ff.head) begin
         for (int i = 0; i < 3; i++) begin
            push_items[i]   = head_v[i];
            push_items[i+4] = tail_v[i];
         end
         push_items[3] = centre_v;
      end else begin
         push_items[0] = centre_v;
         for (int i = 0; i < 3; i++) begin
            push_items[i+1] = tail_v[i];
         end
      end
      push_cnt = op_count(s3_op_ff);
   end

   // ---------------- result queue
   rsp_item_type head_item;

   cswf_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_cnt   (push_cnt),
      .push_items (push_items),
      .pop        (rsp_tvalid && rsp_tready),
      .head_item  (head_item),
      .count      (fifo_count)
   );

   assign rsp_tvalid = (fifo_count != '0);
   assign rsp_tdata  = head_item.value;
   assign rsp_tlast  = head_item.last;

endmodule

// ===== rtl/cswf_checker.sv =====
// Port-level checks for the cosmic spike window filter, bound to the top level.
`timescale 1ns / 1ps

module cswf_checker
   import cswf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic       in_xfer, out_xfer;
   logic [15:0] pend_ff, pend_in;
   logic [15:0] lastpend_ff, lastpend_in;

   assign in_xfer  = req_tvalid && req_tready;
   assign out_xfer = rsp_tvalid && rsp_tready;

   // samples taken minus results delivered; vectors closed minus vectors delivered
   assign pend_in     = pend_ff + 16'(in_xfer) - 16'(out_xfer);
   assign lastpend_in = lastpend_ff + 16'(in_xfer && req_tlast)
                      - 16'(out_xfer && rsp_tlast);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= '0;
         lastpend_ff <= '0;
      end else begin
         pend_ff     <= pend_in;
         lastpend_ff <= lastpend_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_no_extra: assert property (@(posedge clock) disable iff (reset) !pend_ff[15])
      else $error("more results delivered than samples taken");

   a_no_extra_last: assert property (@(posedge clock) disable iff (reset)
      !lastpend_ff[15])
      else $error("vector end delivered before its last sample arrived");

endmodule

bind cosmic_spike_window_filter cswf_checker u_cswf_checker (.*);
